// ----- hdl/silence_run_length_encoder_top_defines.svh -----
// assertion macros for the port checker of the silence run encoder
// no dependencies
`ifndef SILENCE_RUN_LENGTH_ENCODER_TOP_DEFINES_SVH
`define SILENCE_RUN_LENGTH_ENCODER_TOP_DEFINES_SVH

// property checked at every rising edge, ignored while reset is high
`define SRLE_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every rising edge, reset included
`define SRLE_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/srle_pkg.sv -----
// shared types, constants and helper functions of the silence run encoder
// no dependencies
`timescale 1ns / 1ps

package srle_pkg;

   localparam int WIN = 8;                     // look-ahead depth in bytes
   localparam int CNT_W = $clog2(WIN + 1);     // holds 0 .. WIN

   localparam logic [7:0] RUN_CODE = 8'h80;
   localparam logic [7:0] ESC_CODE = 8'h81;
   localparam logic [7:0] MAX_RUN_DEFAULT = 8'd255;

   localparam logic [7:0] RST_SILENCE_LIMIT = 8'd1;
   localparam logic [3:0] RST_START_COUNT = 4'd5;
   localparam logic [3:0] RST_STOP_COUNT = 4'd1;
   localparam logic [7:0] RST_MAX_RUN = 8'd255;

   typedef enum logic [1:0] {
      REG_SILENCE_LIMIT = 2'd0,
      REG_START_COUNT   = 2'd1,
      REG_STOP_COUNT    = 2'd2,
      REG_MAX_RUN       = 2'd3
   } csr_reg_type;

   typedef struct packed {
      logic clear;   // empty every cell
      logic shift;   // every cell takes its upper neighbour
   } cell_ctrl_type;

   function automatic logic is_silent(input logic [7:0] value, input logic [7:0] limit);
      logic [8:0] sum;
      sum = {1'b0, value} + {1'b0, limit};
      return (value < limit) || (sum > 9'd256);
   endfunction

   function automatic logic [CNT_W-1:0] clamp_count(input logic [3:0] count);
      if (int'(count) > WIN) begin
         return CNT_W'(WIN);
      end
      return CNT_W'(count);
   endfunction

endpackage

// ----- hdl/srle_cell.sv -----
// one look-ahead cell: holds a byte and its valid flag, shifts down on a pop
// depends on srle_pkg
`timescale 1ns / 1ps

module srle_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  srle_pkg::cell_ctrl_type ctrl,
   input  logic                  load,
   input  logic [7:0]            load_byte,
   input  logic [7:0]            next_byte,
   input  logic                  next_valid,
   input  logic [7:0]            silence_limit,
   output logic [7:0]            cell_byte,
   output logic                  cell_valid,
   output logic                  cell_silent
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in;
   logic       valid_ff;
   logic       valid_in;

   always_comb begin
      byte_in = byte_ff;
      valid_in = valid_ff;
      priority if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (load) begin
         byte_in = load_byte;
         valid_in = 1'b1;
      end else if (ctrl.shift) begin
         byte_in = next_byte;
         valid_in = next_valid;
      end else begin
         // hold
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign cell_byte = byte_ff;
   assign cell_valid = valid_ff;
   // an empty cell stands for end of stream, never silent
   assign cell_silent = valid_ff && srle_pkg::is_silent(byte_ff, silence_limit);

endmodule

// ----- hdl/srle_ctrl.sv -----
// run decision engine, fill count, configuration registers and output register
// depends on srle_pkg
`timescale 1ns / 1ps

module srle_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic                     req_tlast,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [7:0]               rsp_tdata,
   output logic                     rsp_tlast,
   input  logic                     csr_we,
   input  logic [1:0]               csr_addr,
   input  logic [7:0]               csr_wdata,
   input  logic [7:0]               head_byte,
   input  logic [srle_pkg::WIN-1:0] silent_vec,
   output srle_pkg::cell_ctrl_type  cell_ctrl,
   output logic [srle_pkg::WIN-1:0] wr_sel,
   output logic [7:0]               silence_limit
);

   localparam int CW = srle_pkg::CNT_W;

   logic [7:0]    limit_ff, limit_in;
   logic [3:0]    startc_ff, startc_in;
   logic [3:0]    stopc_ff, stopc_in;
   logic [7:0]    maxrun_ff, maxrun_in;

   logic [CW-1:0] fill_ff, fill_in;
   logic          primed_ff, primed_in;
   logic          in_run_ff, in_run_in;
   logic          after_run_ff, after_run_in;
   logic          last_held_ff, last_held_in;
   logic [7:0]    run_cnt_ff, run_cnt_in;
   logic          pend_valid_ff, pend_valid_in;
   logic [7:0]    pend_byte_ff, pend_byte_in;
   logic          pend_last_ff, pend_last_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_byte_ff, rsp_byte_in;
   logic          rsp_last_ff, rsp_last_in;

   logic          act;
   logic          push;
   logic          pop;
   logic          clear;
   logic          absorb;
   logic          emit;
   logic [7:0]    emit_byte;
   logic          emit_last;
   logic [CW-1:0] startc;
   logic [CW-1:0] stopc;
   logic [7:0]    run_limit;
   logic [srle_pkg::WIN-1:0] ge_start;
   logic [srle_pkg::WIN-1:0] ge_stop;
   logic          start_ok;
   logic          run_ended;
   logic          fill_zero;
   logic          fill_one;
   logic [7:0]    literal;
   logic [8:0]    run_inc;
   logic [CW-1:0] wpos;

   assign startc = srle_pkg::clamp_count(startc_ff);
   assign stopc = srle_pkg::clamp_count(stopc_ff);
   assign run_limit = (maxrun_ff == 8'd0) ? srle_pkg::MAX_RUN_DEFAULT : maxrun_ff;

   always_comb begin
      for (int k = 0; k < srle_pkg::WIN; k++) begin
         ge_start[k] = (CW'(k) >= startc);
         ge_stop[k] = (CW'(k) >= stopc);
      end
   end

   assign start_ok = &(silent_vec | ge_start);
   assign run_ended = ~|(silent_vec & ~ge_stop);
   assign fill_zero = (fill_ff == '0);
   assign fill_one = (fill_ff == CW'(1));
   assign literal = (head_byte == srle_pkg::RUN_CODE) ? srle_pkg::ESC_CODE : head_byte;
   assign run_inc = {1'b0, run_cnt_ff} + 9'd1;

   assign act = !rsp_valid_ff || rsp_tready;
   assign req_tready = !last_held_ff && (fill_ff != CW'(srle_pkg::WIN));
   assign push = req_tvalid && req_tready;

   // one decision per cycle while the output register can take a word, at most one word out
   always_comb begin
      pop = 1'b0;
      clear = 1'b0;
      absorb = 1'b0;
      emit = 1'b0;
      emit_byte = 8'h00;
      emit_last = 1'b0;
      in_run_in = in_run_ff;
      after_run_in = after_run_ff;
      run_cnt_in = run_cnt_ff;
      pend_valid_in = pend_valid_ff;
      pend_byte_in = pend_byte_ff;
      pend_last_in = pend_last_ff;

      if (act) begin
         priority if (pend_valid_ff) begin
            emit = 1'b1;
            emit_byte = pend_byte_ff;
            emit_last = pend_last_ff;
            pend_valid_in = 1'b0;
         end else if (last_held_ff && fill_zero && !in_run_ff) begin
            clear = 1'b1;
         end else if (last_held_ff && !primed_ff) begin
            // short stream goes out as it came
            if (!fill_zero) begin
               emit = 1'b1;
               emit_byte = head_byte;
               emit_last = fill_one;
               pop = 1'b1;
            end
         end else if (primed_ff) begin
            if (in_run_ff) begin
               if (last_held_ff || fill_ff >= stopc) begin
                  if (run_ended) begin
                     if (run_cnt_ff != 8'd0) begin
                        emit = 1'b1;
                        emit_byte = srle_pkg::RUN_CODE;
                        pend_valid_in = 1'b1;
                        pend_byte_in = run_cnt_ff;
                        pend_last_in = last_held_ff && fill_zero;
                     end
                     in_run_in = 1'b0;
                     run_cnt_in = 8'd0;
                     after_run_in = 1'b1;
                  end else begin
                     absorb = 1'b1;
                  end
               end
            end else if (!fill_zero) begin
               if (after_run_ff) begin
                  emit = 1'b1;
                  emit_byte = literal;
                  emit_last = last_held_ff && fill_one;
                  pop = 1'b1;
                  after_run_in = 1'b0;
               end else if (last_held_ff || fill_ff >= startc) begin
                  if (start_ok) begin
                     in_run_in = 1'b1;
                     absorb = 1'b1;
                  end else begin
                     emit = 1'b1;
                     emit_byte = literal;
                     emit_last = last_held_ff && fill_one;
                     pop = 1'b1;
                  end
               end
            end
         end else begin
            // row still filling, nothing to decide yet
         end

         if (absorb) begin
            pop = 1'b1;
            if (run_inc >= {1'b0, run_limit}) begin
               emit = 1'b1;
               emit_byte = srle_pkg::RUN_CODE;
               pend_valid_in = 1'b1;
               pend_byte_in = run_limit;
               pend_last_in = last_held_ff && fill_one;
               run_cnt_in = 8'd0;
            end else begin
               run_cnt_in = run_inc[7:0];
            end
         end
      end
   end

   // fill count, stream flags and the output register
   always_comb begin
      fill_in = fill_ff + CW'(push) - CW'(pop);
      primed_in = primed_ff;
      last_held_in = last_held_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in = rsp_byte_ff;
      rsp_last_in = rsp_last_ff;
      if (push && fill_in == CW'(srle_pkg::WIN)) begin
         primed_in = 1'b1;
      end
      if (push && req_tlast) begin
         last_held_in = 1'b1;
      end
      if (clear) begin
         fill_in = '0;
         primed_in = 1'b0;
         last_held_in = 1'b0;
      end
      if (act) begin
         rsp_valid_in = emit;
         rsp_byte_in = emit_byte;
         rsp_last_in = emit_last;
      end
   end

   always_comb begin
      limit_in = limit_ff;
      startc_in = startc_ff;
      stopc_in = stopc_ff;
      maxrun_in = maxrun_ff;
      if (csr_we) begin
         unique case (srle_pkg::csr_reg_type'(csr_addr))
            srle_pkg::REG_SILENCE_LIMIT: limit_in = csr_wdata;
            srle_pkg::REG_START_COUNT:   startc_in = csr_wdata[3:0];
            srle_pkg::REG_STOP_COUNT:    stopc_in = csr_wdata[3:0];
            srle_pkg::REG_MAX_RUN:       maxrun_in = csr_wdata;
         endcase
      end
   end

   // a pushed word lands above the held ones, one lower when the row shifts
   assign wpos = fill_ff - CW'(pop);

   always_comb begin
      for (int i = 0; i < srle_pkg::WIN; i++) begin
         wr_sel[i] = push && (CW'(i) == wpos);
      end
   end

   assign cell_ctrl.clear = clear;
   assign cell_ctrl.shift = pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= srle_pkg::RST_SILENCE_LIMIT;
         startc_ff <= srle_pkg::RST_START_COUNT;
         stopc_ff <= srle_pkg::RST_STOP_COUNT;
         maxrun_ff <= srle_pkg::RST_MAX_RUN;
         fill_ff <= '0;
         primed_ff <= 1'b0;
         in_run_ff <= 1'b0;
         after_run_ff <= 1'b0;
         last_held_ff <= 1'b0;
         run_cnt_ff <= 8'd0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_ff <= limit_in;
         startc_ff <= startc_in;
         stopc_ff <= stopc_in;
         maxrun_ff <= maxrun_in;
         fill_ff <= fill_in;
         primed_ff <= clear ? 1'b0 : primed_in;
         in_run_ff <= clear ? 1'b0 : in_run_in;
         after_run_ff <= clear ? 1'b0 : after_run_in;
         last_held_ff <= last_held_in;
         run_cnt_ff <= clear ? 8'd0 : run_cnt_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_byte_ff <= pend_byte_in;
      pend_last_ff <= pend_last_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_byte_ff;
   assign rsp_tlast = rsp_last_ff;
   assign silence_limit = limit_ff;

endmodule

// ----- hdl/silence_run_length_encoder_top.sv -----
// top level of the silence run encoder: row of look-ahead cells and the engine
// depends on srle_pkg, srle_cell, srle_ctrl
`timescale 1ns / 1ps

// Usage
// req_ channel carries the input stream, one byte a word, tlast on the final
// byte. rsp_ channel carries the encoded stream: literals (0x80 sent as 0x81),
// or 0x80 followed by a run length; tlast marks the final encoded word.
// csr_ is a plain write port, taken whenever csr_we is high; write it only
// while no stream is in flight.
// Look-ahead: nothing comes out until 8 bytes are held (or the stream ends);
// a stream that ends sooner goes out unchanged, 0x80 included. Once primed
// the row stays nearly full (7 words held with input and output both
// flowing); a literal moves down the cells, then into the output register.
// Throughput: one word a cycle in and out in steady state with rsp_tready high;
// each 0x80/length pair takes two output words; a run absorbs one byte a
// cycle without output unless rsp_ stalls. With start_count or stop_count
// of 8 or more a decision needs all 8 cells full, which blocks input, so
// input and decisions alternate. After the final byte the look-ahead drains
// at one decision a cycle unless stalled, then a stream clear lets req_tready rise.
// Reset clears all stream state and loads the register defaults.
// A stalled receiver holds the output word; the row of cells keeps taking
// input until all 8 cells are full, then req_tready drops.

module silence_run_length_encoder_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast,
   input  logic       csr_we,
   input  logic [1:0] csr_addr,
   input  logic [7:0] csr_wdata
);

   srle_pkg::cell_ctrl_type  cell_ctrl;
   logic [srle_pkg::WIN-1:0] wr_sel;
   logic [srle_pkg::WIN-1:0] silent_vec;
   logic [7:0]               silence_limit;
   logic [7:0]               cell_byte [0:srle_pkg::WIN];
   logic                     cell_valid [0:srle_pkg::WIN];

   // nothing above the top cell
   assign cell_byte[srle_pkg::WIN] = 8'h00;
   assign cell_valid[srle_pkg::WIN] = 1'b0;

   for (genvar i = 0; i < srle_pkg::WIN; i++) begin : g_cell
      srle_cell u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctrl          (cell_ctrl),
         .load          (wr_sel[i]),
         .load_byte     (req_tdata),
         .next_byte     (cell_byte[i+1]),
         .next_valid    (cell_valid[i+1]),
         .silence_limit (silence_limit),
         .cell_byte     (cell_byte[i]),
         .cell_valid    (cell_valid[i]),
         .cell_silent   (silent_vec[i])
      );
   end

   srle_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .csr_we        (csr_we),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .head_byte     (cell_byte[0]),
      .silent_vec    (silent_vec),
      .cell_ctrl     (cell_ctrl),
      .wr_sel        (wr_sel),
      .silence_limit (silence_limit)
   );

endmodule

// ----- hdl/srle_checker.sv -----
// port-level checks of the silence run encoder, bound to the top level
// depends on silence_run_length_encoder_top_defines.svh
`timescale 1ns / 1ps
`include "silence_run_length_encoder_top_defines.svh"

module srle_port_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       req_tlast,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   logic       rsp_stall;
   logic [9:0] rsp_word;
   logic       last_in;

   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_word = {rsp_tvalid, rsp_tlast, rsp_tdata};
   assign last_in = req_tvalid && req_tready && req_tlast;

   // a stalled output word stays put
   `SRLE_ASSERT(a_rsp_hold, clock, reset, rsp_stall |=> $stable(rsp_word), "stalled word changed")

   // no new stream starts while the final byte is still draining
   `SRLE_ASSERT(a_last_blocks, clock, reset, last_in |=> !req_tready, "input after final byte")

   // reset leaves an empty block ready for input
   `SRLE_ASSERT_NR(a_reset_state, clock, reset |=> !rsp_tvalid && req_tready, "not idle after reset")

endmodule

bind silence_run_length_encoder_top srle_port_checker u_srle_checker (.*);

// ----- verif/srle_checker.sv -----
// checker for the silence run encoder: tracks register writes, predicts the
// encoded words from every accepted input word and compares them on the rsp_ side
// depends on srle_pkg
`timescale 1ns / 1ps

module srle_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,   // [7:0] out_byte
   input  logic       rsp_tlast,
   input  logic       csr_we,
   input  logic [1:0] csr_addr,
   input  logic [7:0] csr_wdata,
   output int         mismatches,
   output int         backlog,
   output int         words_out
);

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } coded_word_type;

   coded_word_type coded_q[$];
   logic [7:0]  step_q[$];

   // register copies
   logic [7:0] lim_r;
   logic [3:0] startc_r;
   logic [3:0] stopc_r;
   logic [7:0] maxrun_r;

   // look-ahead ring and run state
   logic [7:0] ring [srle_pkg::WIN];
   int         head;
   int         fill;
   int         run_len;
   bit         primed;
   bit         in_run;
   bit         after_run;
   int         n_bad;
   int         n_out;

   function automatic bit quiet(input int v);
      int l;
      l = int'(lim_r);
      if (v < 0) return 1'b0;
      return (v < l) || (v + l > 256);
   endfunction

   // entry k places past the head, -1 once past the held bytes
   function automatic int ahead(input int k);
      if (k >= fill) return -1;
      return int'(ring[(head + k) % srle_pkg::WIN]);
   endfunction

   task automatic clear_stream();
      for (int k = 0; k < srle_pkg::WIN; k++) ring[k] = 8'h00;
      head = 0;
      fill = 0;
      run_len = 0;
      primed = 1'b0;
      in_run = 1'b0;
      after_run = 1'b0;
   endtask

   task automatic put_byte(input logic [7:0] b);
      if (step_q.size() < 16) step_q.push_back(b);
   endtask

   task automatic drop_head();
      head = (head + 1) % srle_pkg::WIN;
      fill--;
   endtask

   task automatic put_literal();
      int v;
      v = ahead(0);
      put_byte((v == int'(srle_pkg::RUN_CODE)) ? srle_pkg::ESC_CODE : 8'(v));
      drop_head();
   endtask

   task automatic absorb_one();
      int cap;
      cap = (maxrun_r == 8'd0) ? 255 : int'(maxrun_r);
      drop_head();
      run_len++;
      if (run_len >= cap) begin
         put_byte(srle_pkg::RUN_CODE);
         put_byte(8'(cap));
         run_len = 0;
      end
   endtask

   task automatic decide(input bit at_end);
      int startc;
      int stopc;
      int k;
      bit done;
      bit hit;
      startc = (int'(startc_r) > srle_pkg::WIN) ? srle_pkg::WIN : int'(startc_r);
      stopc = (int'(stopc_r) > srle_pkg::WIN) ? srle_pkg::WIN : int'(stopc_r);
      done = 1'b0;
      while (!done) begin
         if (in_run) begin
            if (!at_end && fill < stopc) begin
               done = 1'b1;
            end else begin
               hit = 1'b1;
               for (k = 0; k < stopc; k++) if (quiet(ahead(k))) hit = 1'b0;
               if (hit) begin
                  if (run_len > 0) begin
                     put_byte(srle_pkg::RUN_CODE);
                     put_byte(8'(run_len));
                  end
                  in_run = 1'b0;
                  run_len = 0;
                  after_run = 1'b1;
               end else begin
                  absorb_one();
               end
            end
         end else if (fill == 0) begin
            done = 1'b1;
         end else if (after_run) begin
            // the word right after a run goes out without a start check
            put_literal();
            after_run = 1'b0;
         end else if (!at_end && fill < startc) begin
            done = 1'b1;
         end else begin
            hit = 1'b1;
            for (k = 0; k < startc; k++) if (!quiet(ahead(k))) hit = 1'b0;
            if (hit) begin
               in_run = 1'b1;
               run_len = 0;
               absorb_one();
            end else begin
               put_literal();
            end
         end
      end
   endtask

   task automatic take_byte(input logic [7:0] b, input logic l);
      coded_word_type w;
      int k;
      step_q.delete();
      if (fill < srle_pkg::WIN) begin
         ring[(head + fill) % srle_pkg::WIN] = b;
         fill++;
      end
      if (!primed) begin
         if (fill >= srle_pkg::WIN) begin
            primed = 1'b1;
            decide(l);
         end else if (l) begin
            // short stream leaves as it came, no escaping
            for (k = 0; k < fill; k++) put_byte(8'(ahead(k)));
         end
      end else begin
         decide(l);
      end
      for (k = 0; k < step_q.size(); k++) begin
         w.data = step_q[k];
         w.last = l && (k == step_q.size() - 1);
         coded_q.push_back(w);
      end
      if (l) clear_stream();
   endtask

   always @(posedge clock) begin
      coded_word_type want;
      if (reset) begin
         lim_r = srle_pkg::RST_SILENCE_LIMIT;
         startc_r = srle_pkg::RST_START_COUNT;
         stopc_r = srle_pkg::RST_STOP_COUNT;
         maxrun_r = srle_pkg::RST_MAX_RUN;
         clear_stream();
         coded_q.delete();
         n_bad = 0;
         n_out = 0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               srle_pkg::REG_SILENCE_LIMIT: lim_r = csr_wdata;
               srle_pkg::REG_START_COUNT:   startc_r = csr_wdata[3:0];
               srle_pkg::REG_STOP_COUNT:    stopc_r = csr_wdata[3:0];
               srle_pkg::REG_MAX_RUN:       maxrun_r = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) take_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            n_out++;
            if (coded_q.size() == 0) begin
               $display("%0t: word %02h last %0b with nothing expected",
                        $time, rsp_tdata, rsp_tlast);
               n_bad++;
            end else begin
               want = coded_q.pop_front();
               if (rsp_tdata !== want.data) begin
                  $display("%0t: out_byte expected %02h actual %02h",
                           $time, want.data, rsp_tdata);
                  n_bad++;
               end
               if (rsp_tlast !== want.last) begin
                  $display("%0t: out_last expected %0b actual %0b",
                           $time, want.last, rsp_tlast);
                  n_bad++;
               end
            end
         end
      end
      mismatches <= n_bad;
      backlog <= coded_q.size();
      words_out <= n_out;
   end

endmodule

// ----- verif/tb_top.sv -----
// testbench top for the silence run encoder: clock, reset, register settings,
// byte streams with bursty sender and stalling receiver, final verdict
// depends on srle_pkg, silence_run_length_encoder_top, srle_checker
`timescale 1ns / 1ps

module tb_top;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic [7:0] req_tdata = 8'h00;
   logic       req_tlast = 1'b0;
   logic       rsp_tready = 1'b0;
   logic       csr_we = 1'b0;
   logic [1:0] csr_addr = 2'd0;
   logic [7:0] csr_wdata = 8'h00;
   wire        req_tready;
   wire        rsp_tvalid;
   wire [7:0]  rsp_tdata;
   wire        rsp_tlast;

   int mismatches;
   int backlog;
   int words_out;

   logic [7:0] cur_limit = srle_pkg::RST_SILENCE_LIMIT;
   logic [7:0] stream_q[$];
   int words_in = 0;
   int streams = 0;
   int settings = 1;
   int burst_left = 0;
   int rx_mode = 0;
   int rx_left = 0;
   int rx_tick = 0;

   // fixed settings: extremes, zero counts, oversized counts, big limits
   int lim_tab[9]   = '{16, 128, 1, 0, 40, 200, 64, 255, 8};
   int start_tab[9] = '{3, 8, 1, 0, 15, 2, 4, 0, 6};
   int stop_tab[9]  = '{2, 8, 1, 0, 12, 3, 0, 5, 1};
   int max_tab[9]   = '{10, 255, 1, 0, 4, 7, 255, 2, 3};

   silence_run_length_encoder_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   srle_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .mismatches (mismatches),
      .backlog    (backlog),
      .words_out  (words_out)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("run timed out with %0d words still expected", backlog);
      $display("*** FAILED ***");
      $finish;
   end

   // receiver: always ready, mostly ready, a fixed stall pattern or coin flips
   always @(negedge clock) begin
      if (rx_left == 0) begin
         rx_mode = $urandom_range(0, 3);
         rx_left = $urandom_range(20, 150);
      end
      rx_left--;
      rx_tick++;
      case (rx_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         2: rsp_tready <= ((rx_tick % 5) < 3);
         default: rsp_tready <= 1'($urandom_range(0, 1));
      endcase
   end

   function automatic logic [7:0] pick_quiet();
      int l;
      l = int'(cur_limit);
      if (l == 0) return 8'($urandom);
      if (l >= 2 && $urandom_range(0, 1)) return 8'($urandom_range(257 - l, 255));
      return 8'($urandom_range(0, l - 1));
   endfunction

   function automatic logic [7:0] pick_loud();
      int l;
      int v;
      l = int'(cur_limit);
      if ($urandom_range(0, 5) == 0) begin
         return $urandom_range(0, 1) ? srle_pkg::RUN_CODE : srle_pkg::ESC_CODE;
      end
      v = $urandom_range(0, 255);
      for (int t = 0; t < 16 && (v < l || v + l > 256); t++) v = $urandom_range(0, 255);
      return 8'(v);
   endfunction

   task automatic send_word(input logic [7:0] b, input logic l);
      int gap;
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) == 0) begin
            gap = 0;
            burst_left = $urandom_range(30, 80);
         end else begin
            gap = $urandom_range(1, 8);
            burst_left = $urandom_range(1, 12);
         end
         repeat (gap) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= l;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_in++;
   endtask

   // hold the sender back until every predicted word has arrived
   task automatic drain_wait();
      @(negedge clock);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (backlog != 0) @(posedge clock);
   endtask

   task automatic settle();
      drain_wait();
      repeat (30) @(posedge clock);
   endtask

   task automatic wr_reg(input srle_pkg::csr_reg_type idx, input logic [7:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      if (idx == srle_pkg::REG_SILENCE_LIMIT) cur_limit = val;
   endtask

   task automatic apply_setting(input int lim, input int st, input int sp, input int mr);
      settle();
      wr_reg(srle_pkg::REG_SILENCE_LIMIT, 8'(lim));
      wr_reg(srle_pkg::REG_START_COUNT, 8'(st));
      wr_reg(srle_pkg::REG_STOP_COUNT, 8'(sp));
      wr_reg(srle_pkg::REG_MAX_RUN, 8'(mr));
      @(negedge clock);
      csr_we <= 1'b0;
      settings++;
   endtask

   // silent stretches of random length between short loud groups, or pure noise
   task automatic build_stream(input int len, input bit noisy);
      int n;
      stream_q.delete();
      while (stream_q.size() < len) begin
         if (noisy) begin
            stream_q.push_back(8'($urandom));
         end else begin
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 24)
                                            : $urandom_range(0, 9);
            repeat (n) stream_q.push_back(pick_quiet());
            n = $urandom_range(1, 5);
            repeat (n) stream_q.push_back(pick_loud());
         end
      end
      while (stream_q.size() > len) void'(stream_q.pop_back());
   endtask

   task automatic send_stream(input int pause_at);
      for (int i = 0; i < stream_q.size(); i++) begin
         if (i == pause_at) drain_wait();
         send_word(stream_q[i], i == stream_q.size() - 1);
      end
      streams++;
   endtask

   task automatic run_streams(input int budget);
      int sent;
      int len;
      sent = 0;
      while (sent < budget) begin
         len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 7) : $urandom_range(8, 24);
         build_stream(len, $urandom_range(0, 3) == 0);
         send_stream(($urandom_range(0, 9) == 0) ? $urandom_range(0, len - 1) : -1);
         sent += len;
      end
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // register defaults: short streams pass through untouched
      stream_q = '{8'h80, 8'h00, 8'hFF};
      send_stream(-1);
      stream_q = '{8'h55};
      send_stream(-1);
      // runs, escape of the run code, extremes, pause mid stream
      stream_q = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80, 8'hFF, 8'h7F, 8'h00,
                   8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h81, 8'h00, 8'h00, 8'h00, 8'hFE};
      send_stream(10);

      for (int p = 0; p < 9; p++) begin
         apply_setting(lim_tab[p], start_tab[p], stop_tab[p], max_tab[p]);
         run_streams(10);
      end
      repeat (2) begin
         apply_setting($urandom_range(0, 255), $urandom_range(0, 15),
                       $urandom_range(0, 15), $urandom_range(0, 255));
         run_streams(10);
      end
      settle();

      $display("sent %0d streams (%0d words) under %0d register settings",
               streams, words_in, settings);
      $display("checked %0d encoded words, %0d mismatches", words_out, mismatches);
      if (mismatches == 0 && backlog == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
